// ===== design/cofg_pkg.sv =====
// Shared types, widths and reset values for the charger overvoltage FET guard.
// No dependencies; every other design file imports this package.
`default_nettype none

package cofg_pkg;

    localparam int AVERAGE_COUNT_DEF = 10;

    localparam int SAMPLE_W  = 10;
    localparam int GAIN_W    = 22;
    localparam int OFFSET_W  = 12;
    localparam int MV_W      = 15;
    localparam int BAT_W     = 16;
    localparam int CUR_W     = 14;
    localparam int CONFIRM_W = 16;
    localparam int HOLD_W    = 17;

    localparam int Q_SHIFT       = 16;
    localparam int CURRENT_MUL   = 625;
    localparam int CURRENT_SHIFT = 6;

    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SOURCE_GAIN,
        REG_SOURCE_OFFSET,
        REG_BATTERY_GAIN,
        REG_BATTERY_OFFSET,
        REG_OVERVOLTAGE,
        REG_CUTOFF,
        REG_CONFIRM,
        REG_HOLD
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]    source_gain;
        logic [OFFSET_W-1:0]  source_offset;
        logic [GAIN_W-1:0]    battery_gain;
        logic [OFFSET_W-1:0]  battery_offset;
        logic [MV_W-1:0]      overvoltage_mv;
        logic [MV_W-1:0]      cutoff_mv;
        logic [CONFIRM_W-1:0] confirm_count;
        logic [HOLD_W-1:0]    hold_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        source_gain:    GAIN_W'(1619200),
        source_offset:  OFFSET_W'(134),
        battery_gain:   GAIN_W'(1699144),
        battery_offset: OFFSET_W'(-82),
        overvoltage_mv: MV_W'(15000),
        cutoff_mv:      MV_W'(13000),
        confirm_count:  CONFIRM_W'(15000),
        hold_count:     HOLD_W'(100000)
    };

    localparam logic [MV_W-1:0]         MIN_SEEN_RESET  = MV_W'(20000);
    localparam logic signed [BAT_W-1:0] OPEN_BATTERY_MV = BAT_W'(1000);

    // averaged ADC counts of one window
    typedef struct packed {
        logic [SAMPLE_W-1:0] source;
        logic [SAMPLE_W-1:0] battery;
        logic [SAMPLE_W-1:0] current;
        logic                blink;
    } avg_tok_t;

    // calibrated readings plus battery threshold flags
    typedef struct packed {
        logic [MV_W-1:0]         source_mv;
        logic signed [BAT_W-1:0] battery_mv;
        logic [CUR_W-1:0]        current_mv;
        logic                    blink;
        logic                    at_over;
        logic                    at_open;
        logic                    at_cutoff;
    } meas_t;

endpackage

`default_nettype wire

// ===== design/cofg_in_if.sv =====
// Input channel: one ADC set per beat.
// Depends on cofg_pkg.
`default_nettype none

interface cofg_in_if;
    import cofg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] source_sample;
    logic [SAMPLE_W-1:0] battery_sample;
    logic [SAMPLE_W-1:0] current_sample;
    logic                blink_level;

    modport source (
        output valid, source_sample, battery_sample, current_sample, blink_level,
        input  ready
    );

    modport sink (
        input  valid, source_sample, battery_sample, current_sample, blink_level,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/cofg_out_if.sv =====
// Result channel: one averaged, calibrated reading and FET/LED decision per beat.
// Depends on cofg_pkg.
`default_nettype none

interface cofg_out_if;
    import cofg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    fet_on;
    logic                    led_on;
    logic [MV_W-1:0]         source_mv;
    logic signed [BAT_W-1:0] battery_mv;
    logic [CUR_W-1:0]        current_mv;
    logic [MV_W-1:0]         min_source_mv;
    logic [MV_W-1:0]         max_source_mv;
    logic                    overvoltage_active;

    modport source (
        output valid, fet_on, led_on, source_mv, battery_mv, current_mv,
               min_source_mv, max_source_mv, overvoltage_active,
        input  ready
    );

    modport sink (
        input  valid, fet_on, led_on, source_mv, battery_mv, current_mv,
               min_source_mv, max_source_mv, overvoltage_active,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/charger_overvoltage_fet_guard_core.sv =====
// Charger overvoltage FET guard, top level.
// Throughput: one ADC set per cycle, but the set that closes a window waits while
// the result path is stalled; one result beat per AVERAGE_COUNT sets. A window's
// result passes the window total, divider multiply, gain multiply, offset/saturate
// and decision registers. Reset (rst_n, async): registers to defaults, sums,
// counters, FET and LED cleared, minimum source tracker at 20000 mV, maximum at 0.
`default_nettype none

module charger_overvoltage_fet_guard_core #(
    parameter int AVERAGE_COUNT = cofg_pkg::AVERAGE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    cofg_in_if.sink                          in_ch,
    cofg_out_if.source                       out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cofg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cofg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cofg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cofg_pkg::*;

    cfg_t     cfg;
    avg_tok_t tok;
    logic     tok_valid;
    logic     tok_ready;
    meas_t    meas;
    logic     meas_valid;
    logic     meas_ready;

    cofg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cofg_avg #(
        .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    cofg_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok        (tok),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas)
    );

    cofg_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== design/cofg_cfg.sv =====
// APB-style configuration register file for gains, offsets and thresholds.
// Depends on cofg_pkg.
`default_nettype none

module cofg_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cofg_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [cofg_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [cofg_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output cofg_pkg::cfg_t                   cfg
);
    import cofg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SOURCE_GAIN:    cfg_next.source_gain    = pwdata[GAIN_W-1:0];
                REG_SOURCE_OFFSET:  cfg_next.source_offset  = pwdata[OFFSET_W-1:0];
                REG_BATTERY_GAIN:   cfg_next.battery_gain   = pwdata[GAIN_W-1:0];
                REG_BATTERY_OFFSET: cfg_next.battery_offset = pwdata[OFFSET_W-1:0];
                REG_OVERVOLTAGE:    cfg_next.overvoltage_mv = pwdata[MV_W-1:0];
                REG_CUTOFF:         cfg_next.cutoff_mv      = pwdata[MV_W-1:0];
                REG_CONFIRM:        cfg_next.confirm_count  = pwdata[CONFIRM_W-1:0];
                REG_HOLD:           cfg_next.hold_count     = pwdata[HOLD_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SOURCE_GAIN:    prdata = APB_DATA_W'(cfg_reg.source_gain);
            REG_SOURCE_OFFSET:  prdata = APB_DATA_W'(cfg_reg.source_offset);
            REG_BATTERY_GAIN:   prdata = APB_DATA_W'(cfg_reg.battery_gain);
            REG_BATTERY_OFFSET: prdata = APB_DATA_W'(cfg_reg.battery_offset);
            REG_OVERVOLTAGE:    prdata = APB_DATA_W'(cfg_reg.overvoltage_mv);
            REG_CUTOFF:         prdata = APB_DATA_W'(cfg_reg.cutoff_mv);
            REG_CONFIRM:        prdata = APB_DATA_W'(cfg_reg.confirm_count);
            REG_HOLD:           prdata = APB_DATA_W'(cfg_reg.hold_count);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/cofg_avg.sv =====
// Window accumulator and constant divider: sums AVERAGE_COUNT ADC sets, then
// forms truncated averages by reciprocal multiply. Depends on cofg_pkg, cofg_in_if.
`default_nettype none

module cofg_avg #(
    parameter int AVERAGE_COUNT = cofg_pkg::AVERAGE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    cofg_in_if.sink             in_ch,
    output logic                tok_valid,
    input  logic                tok_ready,
    output cofg_pkg::avg_tok_t  tok
);
    import cofg_pkg::*;

    localparam int LOG_N     = $clog2(AVERAGE_COUNT);
    localparam int SUM_W     = SAMPLE_W + LOG_N;
    localparam int CNT_W     = (AVERAGE_COUNT > 1) ? LOG_N : 1;
    localparam int DIV_SHIFT = SUM_W + LOG_N;
    localparam int MUL_W     = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MUL_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVERAGE_COUNT - 1);
    // ceil(2^DIV_SHIFT / N): exact floor division for every sum below 2^SUM_W
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((64'd1 << DIV_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));

    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg  [3];
    logic [SUM_W-1:0]    tot_reg  [3];
    logic                blink_reg;
    logic                win_valid_reg;
    logic                tok_valid_reg;
    avg_tok_t            tok_reg;

    logic [SAMPLE_W-1:0] samp     [3];
    logic [SUM_W-1:0]    add      [3];
    logic [PROD_W-1:0]   prod     [3];
    logic                win_rdy;
    logic                tok_rdy;
    logic                acc;
    logic                close;

    assign samp[0] = in_ch.source_sample;
    assign samp[1] = in_ch.battery_sample;
    assign samp[2] = in_ch.current_sample;

    assign tok_rdy     = !tok_valid_reg || tok_ready;
    assign win_rdy     = !win_valid_reg || tok_rdy;
    assign in_ch.ready = (cnt_reg != LAST_CNT) || win_rdy;
    assign acc         = in_ch.valid && in_ch.ready;
    assign close       = acc && (cnt_reg == LAST_CNT);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            add[i]  = sum_reg[i] + SUM_W'(samp[i]);
            prod[i] = PROD_W'(tot_reg[i]) * PROD_W'(DIV_MUL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            win_valid_reg <= 1'b0;
            tok_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (acc)
            begin
                cnt_reg <= close ? '0 : CNT_W'(cnt_reg + 1'b1);
                for (int i = 0; i < 3; i++)
                begin
                    sum_reg[i] <= close ? '0 : add[i];
                end
            end
            if (win_rdy)
            begin
                win_valid_reg <= close;
            end
            if (tok_rdy)
            begin
                tok_valid_reg <= win_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tot_reg[i] <= add[i];
            end
            blink_reg <= in_ch.blink_level;
        end
        if (tok_rdy && win_valid_reg)
        begin
            tok_reg.source  <= prod[0][DIV_SHIFT +: SAMPLE_W];
            tok_reg.battery <= prod[1][DIV_SHIFT +: SAMPLE_W];
            tok_reg.current <= prod[2][DIV_SHIFT +: SAMPLE_W];
            tok_reg.blink   <= blink_reg;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

`default_nettype wire

// ===== design/cofg_scale.sv =====
// Calibration pipeline: Q16 gain multiply, current scaling, offset add, saturation
// and battery threshold compares. Depends on cofg_pkg.
`default_nettype none

module cofg_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  cofg_pkg::cfg_t      cfg,
    input  logic                tok_valid,
    output logic                tok_ready,
    input  cofg_pkg::avg_tok_t  tok,
    output logic                meas_valid,
    input  logic                meas_ready,
    output cofg_pkg::meas_t     meas
);
    import cofg_pkg::*;

    localparam int GPROD_W = SAMPLE_W + GAIN_W;
    localparam int CPROD_W = SAMPLE_W + 10;
    localparam int QV_W    = GPROD_W - Q_SHIFT;
    localparam int SUMV_W  = QV_W + 2;

    localparam logic signed [SUMV_W-1:0] SRC_MAX = SUMV_W'(32767);
    localparam logic signed [SUMV_W-1:0] BAT_MAX = SUMV_W'(32767);
    localparam logic signed [SUMV_W-1:0] BAT_MIN = SUMV_W'(-2048);

    logic                     prod_valid_reg;
    logic [QV_W-1:0]          src_q_reg;
    logic [QV_W-1:0]          bat_q_reg;
    logic [CUR_W-1:0]         cur_reg;
    logic                     blink_reg;
    logic                     meas_valid_reg;
    meas_t                    meas_reg;

    logic [GPROD_W-1:0]       src_prod;
    logic [GPROD_W-1:0]       bat_prod;
    logic [CPROD_W-1:0]       cur_prod;
    logic signed [SUMV_W-1:0] src_sum;
    logic signed [SUMV_W-1:0] bat_sum;
    logic [MV_W-1:0]          src_sat;
    logic signed [BAT_W-1:0]  bat_sat;
    logic                     prod_rdy;
    logic                     meas_rdy;

    assign meas_rdy  = !meas_valid_reg || meas_ready;
    assign prod_rdy  = !prod_valid_reg || meas_rdy;
    assign tok_ready = prod_rdy;

    assign src_prod = GPROD_W'(tok.source) * GPROD_W'(cfg.source_gain);
    assign bat_prod = GPROD_W'(tok.battery) * GPROD_W'(cfg.battery_gain);
    assign cur_prod = CPROD_W'(tok.current) * CPROD_W'(CURRENT_MUL);

    assign src_sum = $signed({1'b0, src_q_reg})
                   + SUMV_W'($signed(cfg.source_offset));
    assign bat_sum = $signed({1'b0, bat_q_reg})
                   + SUMV_W'($signed(cfg.battery_offset));

    always_comb
    begin
        if (src_sum < 0)
            src_sat = '0;
        else if (src_sum > SRC_MAX)
            src_sat = MV_W'(SRC_MAX);
        else
            src_sat = src_sum[MV_W-1:0];

        if (bat_sum < BAT_MIN)
            bat_sat = BAT_W'(BAT_MIN);
        else if (bat_sum > BAT_MAX)
            bat_sat = BAT_W'(BAT_MAX);
        else
            bat_sat = bat_sum[BAT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            meas_valid_reg <= 1'b0;
        end
        else
        begin
            if (prod_rdy)
            begin
                prod_valid_reg <= tok_valid;
            end
            if (meas_rdy)
            begin
                meas_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_rdy && tok_valid)
        begin
            src_q_reg <= src_prod[GPROD_W-1:Q_SHIFT];
            bat_q_reg <= bat_prod[GPROD_W-1:Q_SHIFT];
            cur_reg   <= cur_prod[CURRENT_SHIFT +: CUR_W];
            blink_reg <= tok.blink;
        end
        if (meas_rdy && prod_valid_reg)
        begin
            meas_reg.source_mv  <= src_sat;
            meas_reg.battery_mv <= bat_sat;
            meas_reg.current_mv <= cur_reg;
            meas_reg.blink      <= blink_reg;
            meas_reg.at_over    <= bat_sat >= $signed({1'b0, cfg.overvoltage_mv});
            meas_reg.at_open    <= bat_sat <= OPEN_BATTERY_MV;
            meas_reg.at_cutoff  <= bat_sat >= $signed({1'b0, cfg.cutoff_mv});
        end
    end

    assign meas_valid = meas_valid_reg;
    assign meas       = meas_reg;

endmodule

`default_nettype wire

// ===== design/cofg_decide.sv =====
// FET/LED decision, overvoltage confirm and hold counters, source min/max
// tracking and the result register. Depends on cofg_pkg, cofg_out_if.
`default_nettype none

module cofg_decide (
    input  logic             clk,
    input  logic             rst_n,
    input  cofg_pkg::cfg_t   cfg,
    input  logic             meas_valid,
    output logic             meas_ready,
    input  cofg_pkg::meas_t  meas,
    cofg_out_if.source       out_ch
);
    import cofg_pkg::*;

    logic                    out_valid_reg;
    logic [CONFIRM_W-1:0]    over_cnt_reg;
    logic [HOLD_W-1:0]       hold_reg;
    logic                    fet_reg;
    logic                    led_reg;
    logic [MV_W-1:0]         min_reg;
    logic [MV_W-1:0]         max_reg;
    logic [MV_W-1:0]         src_reg;
    logic signed [BAT_W-1:0] bat_reg;
    logic [CUR_W-1:0]        cur_reg;
    logic                    active_reg;

    logic [CONFIRM_W-1:0]    over_cnt_next;
    logic [HOLD_W-1:0]       hold_next;
    logic                    fet_next;
    logic                    led_next;
    logic                    active_next;
    logic [MV_W-1:0]         min_next;
    logic [MV_W-1:0]         max_next;
    logic [CONFIRM_W:0]      cnt_inc;
    logic                    rdy;
    logic                    adv;

    assign rdy        = !out_valid_reg || out_ch.ready;
    assign adv        = meas_valid && rdy;
    assign meas_ready = rdy;
    assign cnt_inc    = {1'b0, over_cnt_reg} + (CONFIRM_W + 1)'(1);

    always_comb
    begin
        over_cnt_next = over_cnt_reg;
        hold_next     = hold_reg;
        fet_next      = fet_reg;
        led_next      = led_reg;
        active_next   = 1'b0;
        if (meas.at_over)
        begin
            if (cnt_inc >= {1'b0, cfg.confirm_count})
            begin
                over_cnt_next = cfg.confirm_count;
                hold_next     = cfg.hold_count;
                fet_next      = 1'b0;
                led_next      = meas.blink;
                active_next   = 1'b1;
            end
            else
            begin
                over_cnt_next = cnt_inc[CONFIRM_W-1:0];
            end
        end
        else
        begin
            over_cnt_next = '0;
            if (hold_reg != '0)
            begin
                hold_next   = HOLD_W'(hold_reg - 1'b1);
                led_next    = meas.blink;
                active_next = 1'b1;
            end
            else if (meas.at_open || meas.at_cutoff)
            begin
                fet_next = 1'b0;
                led_next = 1'b0;
            end
            else
            begin
                fet_next = 1'b1;
                led_next = 1'b1;
            end
        end
        min_next = (meas.source_mv <= min_reg) ? meas.source_mv : min_reg;
        max_next = (meas.source_mv >= max_reg) ? meas.source_mv : max_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            over_cnt_reg  <= '0;
            hold_reg      <= '0;
            fet_reg       <= 1'b0;
            led_reg       <= 1'b0;
            min_reg       <= MIN_SEEN_RESET;
            max_reg       <= '0;
        end
        else
        begin
            if (rdy)
            begin
                out_valid_reg <= meas_valid;
            end
            if (adv)
            begin
                over_cnt_reg <= over_cnt_next;
                hold_reg     <= hold_next;
                fet_reg      <= fet_next;
                led_reg      <= led_next;
                min_reg      <= min_next;
                max_reg      <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            src_reg    <= meas.source_mv;
            bat_reg    <= meas.battery_mv;
            cur_reg    <= meas.current_mv;
            active_reg <= active_next;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.fet_on             = fet_reg;
    assign out_ch.led_on             = led_reg;
    assign out_ch.source_mv          = src_reg;
    assign out_ch.battery_mv         = bat_reg;
    assign out_ch.current_mv         = cur_reg;
    assign out_ch.min_source_mv      = min_reg;
    assign out_ch.max_source_mv      = max_reg;
    assign out_ch.overvoltage_active = active_reg;

endmodule

`default_nettype wire
